@@ sv/lpd_pkg.sv @@
package lpd_pkg;

  // Header size in bytes; the length field must lie inside it.
  localparam int unsigned PREVIEW_BYTES = 8;
  localparam int unsigned HDR_IDX_W     = $clog2(PREVIEW_BYTES);

  // Accepted control bytes and where each keeps its length field.
  localparam logic [7:0]  CTRL_LEN_AT_3 = 8'h09;
  localparam logic [7:0]  CTRL_LEN_AT_1 = 8'h0A;
  localparam int unsigned LEN_OFF_A     = 3;
  localparam int unsigned LEN_OFF_B     = 1;

  localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_SHORT   = 2'd2,
    ST_LONG    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2,
    PH_CLOSED = 2'd3
  } phase_e;

  typedef enum logic {
    ENT_SINGLE = 1'b0,
    ENT_BURST  = 1'b1
  } entry_kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_message;
    logic        last_of_message;
    logic [31:0] message_length;
    logic [1:0]  status;
  } out_t;

  typedef logic [PREVIEW_BYTES-1:0][7:0] hdr_t;

  // One queued job: a single result, or a whole header to be played out.
  typedef struct packed {
    entry_kind_e kind;
    out_t        res;
    hdr_t        hdr;
  } entry_t;

  // Request from the front part into the queue.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

@@ sv/lpd_front.sv @@
module lpd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           accept_i,
  input  lpd_pkg::in_t   in_data_i,
  output lpd_pkg::push_t push_o
);
  import lpd_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [HDR_IDX_W-1:0]   cnt_q, cnt_d;
  logic [31:0]            total_q, total_d;
  logic [31:0]            done_q, done_d;
  logic [31:0]            max_q;
  hdr_t                   hdr_q;
  hdr_t                   hdr_next;
  logic                   hdr_we;
  logic [HDR_IDX_W-1:0]   hdr_idx;
  logic [31:0]            dec_len;
  logic [31:0]            done_inc;
  logic                   hdr_last;
  logic                   is_ctrl;

  // Configured maximum message length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // Header as it looks with the current byte written in.
  always_comb begin
    hdr_next = hdr_q;
    for (int k = 0; k < PREVIEW_BYTES; k++) begin
      if (HDR_IDX_W'(k) == cnt_q) begin
        hdr_next[k] = in_data_i.rx_byte;
      end
    end
  end

  // Big-endian length field, placed by the control byte.
  always_comb begin
    if (hdr_q[0] == CTRL_LEN_AT_3) begin
      dec_len = {hdr_next[LEN_OFF_A], hdr_next[LEN_OFF_A+1],
                 hdr_next[LEN_OFF_A+2], hdr_next[LEN_OFF_A+3]};
    end else begin
      dec_len = {hdr_next[LEN_OFF_B], hdr_next[LEN_OFF_B+1],
                 hdr_next[LEN_OFF_B+2], hdr_next[LEN_OFF_B+3]};
    end
  end

  assign hdr_last = (cnt_q == HDR_IDX_W'(PREVIEW_BYTES - 1));
  assign is_ctrl  = (in_data_i.rx_byte == CTRL_LEN_AT_3) ||
                    (in_data_i.rx_byte == CTRL_LEN_AT_1);
  assign done_inc = done_q + 32'd1;
  assign hdr_idx  = (phase_q == PH_WAIT) ? '0 : cnt_q;

  // Phase register and receive counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      cnt_q   <= '0;
      total_q <= '0;
      done_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  // Header buffer; entries are always written before they are decoded.
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_idx] <= in_data_i.rx_byte;
    end
  end

  // Classify each accepted byte and queue the job it calls for.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    done_d  = done_q;
    hdr_we  = 1'b0;
    push_o  = '0;
    push_o.entry.kind = ENT_SINGLE;
    push_o.entry.hdr  = hdr_next;

    if (accept_i) begin
      if (in_data_i.action) begin
        phase_d = PH_WAIT;
        cnt_d   = '0;
        total_d = '0;
        done_d  = '0;
      end else begin
        case (phase_q)
          PH_WAIT: begin
            if (is_ctrl) begin
              hdr_we  = 1'b1;
              cnt_d   = HDR_IDX_W'(1);
              phase_d = PH_HEADER;
            end else begin
              push_o.push                       = 1'b1;
              push_o.entry.res.data_byte        = in_data_i.rx_byte;
              push_o.entry.res.last_of_message  = 1'b1;
              push_o.entry.res.status           = ST_UNKNOWN;
            end
          end
          PH_HEADER: begin
            hdr_we = 1'b1;
            cnt_d  = cnt_q + HDR_IDX_W'(1);
            if (hdr_last) begin
              cnt_d                            = '0;
              total_d                          = dec_len;
              push_o.push                      = 1'b1;
              push_o.entry.res.message_length  = dec_len;
              push_o.entry.res.last_of_message = 1'b1;
              if (dec_len < 32'(PREVIEW_BYTES)) begin
                push_o.entry.res.status = ST_SHORT;
                phase_d                 = PH_CLOSED;
              end else if (dec_len > max_q) begin
                push_o.entry.res.status = ST_LONG;
                phase_d                 = PH_CLOSED;
              end else begin
                push_o.entry.kind                = ENT_BURST;
                push_o.entry.res.status          = ST_DATA;
                push_o.entry.res.last_of_message = (dec_len == 32'(PREVIEW_BYTES));
                if (dec_len == 32'(PREVIEW_BYTES)) begin
                  phase_d = PH_WAIT;
                  total_d = '0;
                  done_d  = '0;
                end else begin
                  phase_d = PH_BODY;
                  done_d  = 32'(PREVIEW_BYTES);
                end
              end
            end
          end
          PH_BODY: begin
            done_d                          = done_inc;
            push_o.push                     = 1'b1;
            push_o.entry.res.data_byte      = in_data_i.rx_byte;
            push_o.entry.res.message_length = total_q;
            push_o.entry.res.status         = ST_DATA;
            if (done_inc >= total_q) begin
              push_o.entry.res.last_of_message = 1'b1;
              phase_d = PH_WAIT;
              total_d = '0;
              done_d  = '0;
            end
          end
          default: begin
            // Closed channel: bytes are ignored until a link reset.
          end
        endcase
      end
    end
  end

endmodule

@@ sv/lpd_queue.sv @@
module lpd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lpd_pkg::push_t  push_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lpd_pkg::entry_t head_o
);
  import lpd_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Two-entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ sv/lpd_back.sv @@
module lpd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  lpd_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lpd_pkg::out_t   out_data_o
);
  import lpd_pkg::*;

  logic [HDR_IDX_W-1:0] idx_q, idx_d;
  logic                 out_valid_q;
  out_t                 out_q;
  out_t                 res;
  logic                 load;
  logic                 idx_end;

  assign load        = head_valid_i && (!out_valid_q || out_ready_i);
  assign idx_end     = (idx_q == HDR_IDX_W'(PREVIEW_BYTES - 1));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Form the next result; a header job stays at the head until its last byte.
  always_comb begin
    res   = head_i.res;
    pop_o = 1'b0;
    idx_d = idx_q;
    case (head_i.kind)
      ENT_BURST: begin
        res.data_byte        = head_i.hdr[idx_q];
        res.first_of_message = (idx_q == '0);
        res.last_of_message  = head_i.res.last_of_message && idx_end;
        if (load) begin
          if (idx_end) begin
            pop_o = 1'b1;
            idx_d = '0;
          end else begin
            idx_d = idx_q + HDR_IDX_W'(1);
          end
        end
      end
      default: begin
        pop_o = load;
      end
    endcase
  end

  // Output register valid and header position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

endmodule

@@ sv/length_prefixed_deframer.sv @@
// Length-prefixed message deframer. One request (a received byte or a link
// reset) is taken per cycle whenever the two-entry job queue between the
// receive front and the output back has room; results leave one per cycle
// through a registered output while out_ready_i is high. A completed valid
// header becomes a single queued job that the back plays out as
// PREVIEW_BYTES results; body bytes, drops and errors give one result each.
// An error closes the channel until a link reset. The user must write
// max_message_length through cfg_we_i/cfg_wdata_i only while the block is
// idle; the block itself does not enforce this. No clearing pass follows reset.
module length_prefixed_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lpd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lpd_pkg::out_t out_data_o
);
  import lpd_pkg::*;

  push_t  push;
  entry_t head;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  assign in_ready_o = !q_full;

  lpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (in_valid_i && in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push)
  );

  lpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  lpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ sv/lpd_checker.sv @@
module lpd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input lpd_pkg::out_t out_data_o
);
  import lpd_pkg::*;

  logic out_take;

  assign out_take = out_valid_o && out_ready_i;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Errors and dropped bytes close a frame on their own.
  a_err_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && (out_data_o.status != ST_DATA) |->
      out_data_o.last_of_message && !out_data_o.first_of_message)
    else $error("error result with wrong frame marks");

  // The header burst continues without a gap after its first byte.
  a_burst_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_data_o.first_of_message && (out_data_o.status == ST_DATA) |=>
      out_valid_o && !out_data_o.first_of_message &&
      (out_data_o.message_length == $past(out_data_o.message_length)))
    else $error("header burst broken after its first byte");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (.*);
